@@ src/tmrm_pkg.sv @@
// Shared constants, sine table and helper functions for the tile map ray marcher.
package tmrm_pkg;

    localparam int MAP_SIDE    = 64;
    localparam int TILE_PIXELS = 64;
    localparam int MAX_STEPS   = 4096;

    localparam int MAP_BITS  = $clog2(MAP_SIDE);
    localparam int TILE_BITS = $clog2(TILE_PIXELS);
    localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W    = 2 * MAP_BITS;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);
    localparam int STEP_LOG  = $clog2(MAX_STEPS);

    localparam int FRAC      = 14;
    localparam int COORD_W   = 20;
    localparam int ANGLE_W   = 12;
    localparam int FOV_W     = 12;
    localparam int COLS_W    = 11;
    localparam int COLUMN_W  = 10;
    localparam int TILE_W    = 6;
    localparam int TRIG_W    = 16;
    localparam int PROD_W    = FOV_W + COLUMN_W;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam int START_W = COORD_W + FRAC - 8;
    localparam int WALK_W  = FRAC + STEP_LOG;
    localparam int SPAN_W  = FRAC + TILE_BITS + MAP_BITS;
    localparam int BASE_W  = (START_W > WALK_W) ? START_W : WALK_W;
    localparam int POS_W   = ((BASE_W + 3) > (SPAN_W + 1)) ? (BASE_W + 3) : (SPAN_W + 1);

    localparam longint unsigned MAP_LIM = longint'(MAP_SIDE) * TILE_PIXELS * 256 - 1;
    localparam longint unsigned HIT_LIM = (MAP_LIM > 64'hFFFFF) ? 64'hFFFFF : MAP_LIM;

    localparam logic [FOV_W-1:0]  FOV_RESET  = FOV_W'(683);
    localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(320);

    localparam logic [CFG_IDX_W-1:0] REG_FIELD_OF_VIEW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 1'd1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    localparam logic [ANGLE_W-1:0] ANG_QUARTER = ANGLE_W'(1024);
    localparam logic [ANGLE_W-1:0] ANG_THREE_Q = ANGLE_W'(3072);

    localparam int QSINE_LAST = 1024;

    typedef logic [14:0] qsine_t [0:QSINE_LAST];

    // Shift-and-subtract floor quotient, used only while building the table.
    function automatic longint unsigned floor_div(input longint unsigned a,
                                                  input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], a[b]};
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic qsine_t build_qsine();
        qsine_t          tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        for (int k = 0; k <= QSINE_LAST; k++) begin
            x    = (longint'(k) * 64'd843314857) >> 11;
            x2   = (x * x) >> 28;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = floor_div((term * x2) >> 28, longint'((2 * n) * (2 * n + 1)));
                if (n[0])
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            v = (sum + 8192) >>> 14;
            if (v > 16384)
                v = 16384;
            tab[k] = v[14:0];
        end
        return tab;
    endfunction

    localparam qsine_t QSINE = build_qsine();

    function automatic logic signed [TRIG_W-1:0] sine_of(input logic [ANGLE_W-1:0] a);
        logic [9:0]                r;
        logic [10:0]               idx;
        logic signed [TRIG_W-1:0]  v;
        r   = a[9:0];
        idx = a[10] ? (11'd1024 - {1'b0, r}) : {1'b0, r};
        v   = signed'({1'b0, QSINE[idx]});
        return a[11] ? -v : v;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_out(input logic signed [POS_W-1:0] p);
        logic [POS_W-7:0] q8;
        q8 = p[POS_W-1:6];
        if (p[POS_W-1])
            return '0;
        else if (64'(q8) > HIT_LIM)
            return COORD_W'(HIT_LIM);
        else
            return COORD_W'(q8);
    endfunction

    typedef struct packed {
        logic                   vld;
        logic                   outside;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
    } probe_t;

endpackage

@@ src/tmrm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module tmrm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tmrm_div.sv @@
// Restoring divider, one quotient bit per cycle, for the column spread of the ray angle.
module tmrm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tmrm_pkg::PROD_W-1:0]  dividend,
    input  logic [tmrm_pkg::COLS_W-1:0]  divisor,
    output logic [tmrm_pkg::PROD_W-1:0]  quotient,
    output logic                         done
);

    import tmrm_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [COLS_W-1:0] rem_reg, rem_next;
    logic [COLS_W-1:0] dvs_reg, dvs_next;

    logic [COLS_W:0]   rem_s;
    logic [COLS_W:0]   diff;
    logic              ge;

    always_comb
    begin
        rem_s = {rem_reg, quo_reg[PROD_W-1]};
        diff  = rem_s - {1'b0, dvs_reg};
        ge    = rem_s >= {1'b0, dvs_reg};

        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[PROD_W-2:0], ge};
            rem_next = ge ? diff[COLS_W-1:0] : rem_s[COLS_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(PROD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ src/tile_map_ray_marcher.sv @@
// Top level of the tile map ray marcher: control, march datapath and tile map.
// Usage:
//   Raise start with a word on action and its fields while busy is low; the word
//   is taken at that edge. A write word (action 0) stores one tile bit; busy
//   stays low. A cast word (action 1) raises busy until its result.
//   The result shows on hit, hit_x, hit_y, ray_angle and vertical_face for
//   exactly one cycle, marked by done; the receiver cannot stall it.
//   A cast runs through the column-spread division and ray angle, the table
//   lookup, then the march steps (one tile map read each) for up to 4096 steps,
//   and a last check of the read that registers the result. One cast is in
//   flight at a time; busy is low in the done cycle.
//   field_of_view and column_count are written through cfg_write, cfg_index and
//   cfg_data; the user writes them only while idle, the block does not enforce it.
//   After reset the block sweeps the 4096-entry tile map to empty, one entry a
//   cycle, and holds busy high throughout; configuration writes are taken during
//   the sweep.
module tile_map_ray_marcher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [tmrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmrm_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic                            action,
    input  logic [tmrm_pkg::TILE_W-1:0]     tile_col,
    input  logic [tmrm_pkg::TILE_W-1:0]     tile_row,
    input  logic                            tile_solid,
    input  logic [tmrm_pkg::COORD_W-1:0]    view_x,
    input  logic [tmrm_pkg::COORD_W-1:0]    view_y,
    input  logic [tmrm_pkg::ANGLE_W-1:0]    view_angle,
    input  logic [tmrm_pkg::COLUMN_W-1:0]   screen_column,
    output logic                            done,
    output logic                            hit,
    output logic [tmrm_pkg::COORD_W-1:0]    hit_x,
    output logic [tmrm_pkg::COORD_W-1:0]    hit_y,
    output logic [tmrm_pkg::ANGLE_W-1:0]    ray_angle,
    output logic                            vertical_face
);

    import tmrm_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_TRIG  = 3'd3;
    localparam logic [2:0] S_MARCH = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [ADDR_W-1:0]        clr_reg, clr_next;
    logic [FOV_W-1:0]         fov_reg, fov_next;
    logic [COLS_W-1:0]        cols_reg, cols_next;
    logic [COORD_W-1:0]       vx_reg, vx_next;
    logic [COORD_W-1:0]       vy_reg, vy_next;
    logic [ANGLE_W-1:0]       va_reg, va_next;
    logic [ANGLE_W-1:0]       ang_reg, ang_next;
    logic signed [TRIG_W-1:0] cs_reg, cs_next;
    logic signed [TRIG_W-1:0] sn_reg, sn_next;
    logic signed [POS_W-1:0]  px_reg, px_next;
    logic signed [POS_W-1:0]  py_reg, py_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    probe_t                   chk_reg, chk_next;
    logic                     done_reg, done_next;
    logic                     hit_reg, hit_next;
    logic [COORD_W-1:0]       hx_reg, hx_next;
    logic [COORD_W-1:0]       hy_reg, hy_next;
    logic                     vf_reg, vf_next;

    logic                     accept;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic                     ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic                     ram_rdata;

    logic                     div_start;
    logic [PROD_W-1:0]        div_dividend;
    logic [COLS_W-1:0]        div_divisor;
    logic [PROD_W-1:0]        div_quotient;
    logic                     div_done;

    logic                     wall;
    logic                     left_going;
    logic                     face0;
    logic signed [POS_W-1:0]  adj_px;
    logic                     outside;

    assign accept = start && !busy;

    always_comb
    begin
        div_start    = accept && (action == ACT_CAST);
        div_dividend = PROD_W'(fov_reg) * PROD_W'(screen_column);
        div_divisor  = (cols_reg == '0) ? COLS_W'(1) : cols_reg;
    end

    tmrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    tmrm_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        outside   = (px_reg[POS_W-1:SPAN_W] != '0) || (py_reg[POS_W-1:SPAN_W] != '0);
        ram_raddr = {py_reg[FRAC+TILE_BITS +: MAP_BITS], px_reg[FRAC+TILE_BITS +: MAP_BITS]};

        wall       = chk_reg.vld && (chk_reg.outside || ram_rdata);
        left_going = (ang_reg > ANG_QUARTER) && (ang_reg < ANG_THREE_Q);
        face0      = chk_reg.px[FRAC +: TILE_BITS] != '0;
        adj_px     = (face0 && left_going) ? (chk_reg.px + POS_W'(1 << FRAC)) : chk_reg.px;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        fov_next   = fov_reg;
        cols_next  = cols_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        va_next    = va_reg;
        ang_next   = ang_reg;
        cs_next    = cs_reg;
        sn_next    = sn_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        step_next  = step_reg;
        chk_next   = chk_reg;
        done_next  = 1'b0;
        hit_next   = hit_reg;
        hx_next    = hx_reg;
        hy_next    = hy_reg;
        vf_next    = vf_reg;
        ram_we     = 1'b0;
        ram_waddr  = {tile_row, tile_col};
        ram_wdata  = tile_solid;

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FIELD_OF_VIEW: fov_next  = cfg_data[FOV_W-1:0];
                REG_COLUMN_COUNT:  cols_next = cfg_data[COLS_W-1:0];
                default:           fov_next  = fov_reg;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 1'b0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(MAP_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_WRITE)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        vx_next    = view_x;
                        vy_next    = view_y;
                        va_next    = view_angle;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    ang_next   = va_reg - (fov_reg >> 1) + div_quotient[ANGLE_W-1:0];
                    state_next = S_TRIG;
                end
            end
            S_TRIG:
            begin
                cs_next    = sine_of(ang_reg + ANG_QUARTER);
                sn_next    = sine_of(ang_reg);
                px_next    = signed'(POS_W'({vx_reg, 6'b0}));
                py_next    = signed'(POS_W'({vy_reg, 6'b0}));
                step_next  = '0;
                chk_next   = '0;
                state_next = S_MARCH;
            end
            S_MARCH:
            begin
                if (step_reg != STEP_W'(MAX_STEPS))
                begin
                    chk_next.vld     = 1'b1;
                    chk_next.outside = outside;
                    chk_next.px      = px_reg;
                    chk_next.py      = py_reg;
                    px_next          = px_reg + POS_W'(cs_reg);
                    py_next          = py_reg + POS_W'(sn_reg);
                    step_next        = step_reg + STEP_W'(1);
                end
                else
                begin
                    chk_next.vld = 1'b0;
                end

                if (wall)
                begin
                    done_next  = 1'b1;
                    hit_next   = 1'b1;
                    hx_next    = clamp_out(adj_px);
                    hy_next    = clamp_out(chk_reg.py);
                    vf_next    = adj_px[FRAC +: TILE_BITS] != '0;
                    state_next = S_IDLE;
                end
                else if ((step_reg == STEP_W'(MAX_STEPS)) && !chk_reg.vld)
                begin
                    done_next  = 1'b1;
                    hit_next   = 1'b0;
                    hx_next    = '0;
                    hy_next    = '0;
                    vf_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            fov_reg   <= FOV_RESET;
            cols_reg  <= COLS_RESET;
            step_reg  <= '0;
            chk_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            fov_reg   <= fov_next;
            cols_reg  <= cols_next;
            step_reg  <= step_next;
            chk_reg   <= chk_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg  <= vx_next;
        vy_reg  <= vy_next;
        va_reg  <= va_next;
        ang_reg <= ang_next;
        cs_reg  <= cs_next;
        sn_reg  <= sn_next;
        px_reg  <= px_next;
        py_reg  <= py_next;
        hit_reg <= hit_next;
        hx_reg  <= hx_next;
        hy_reg  <= hy_next;
        vf_reg  <= vf_next;
    end

    assign busy          = state_reg != S_IDLE;
    assign done          = done_reg;
    assign hit           = hit_reg;
    assign hit_x         = hx_reg;
    assign hit_y         = hy_reg;
    assign ray_angle     = ang_reg;
    assign vertical_face = vf_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_after_march: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_MARCH))
        else $error("result strobe not preceded by march");

    a_no_write_in_march: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARCH || state_reg == S_DIV || state_reg == S_TRIG) |-> !ram_we)
        else $error("tile map written during a cast");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (hit_x == '0 && hit_y == '0 && !vertical_face))
        else $error("miss result carries nonzero fields");
`endif

endmodule

@@ verif/tb_tile_map_ray_marcher.sv @@
// Self-checking testbench for the tile map ray marcher: directed table, then random scenes.
module tb_tile_map_ray_marcher;
    import tmrm_pkg::*;

    localparam int     CYCLE_LIMIT   = 4000000;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     RANDOM_PHASES = 6;
    localparam int     PHASE_ITEMS   = 19;
    localparam longint TILE_SPAN     = longint'(TILE_PIXELS) << FRAC;

    typedef struct packed {
        logic                action;
        logic [TILE_W-1:0]   tile_col;
        logic [TILE_W-1:0]   tile_row;
        logic                tile_solid;
        logic [COORD_W-1:0]  view_x;
        logic [COORD_W-1:0]  view_y;
        logic [ANGLE_W-1:0]  view_angle;
        logic [COLUMN_W-1:0] screen_column;
    } word_t;

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] hit_x;
        logic [COORD_W-1:0] hit_y;
        logic [ANGLE_W-1:0] ray_angle;
        logic               vertical_face;
    } ray_result_t;

    typedef struct packed {
        word_t       w;
        logic        typed;
        ray_result_t want;
    } stim_row_t;

    localparam ray_result_t NO_RESULT = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  start;
    logic                  busy;
    logic                  action;
    logic [TILE_W-1:0]     tile_col;
    logic [TILE_W-1:0]     tile_row;
    logic                  tile_solid;
    logic [COORD_W-1:0]    view_x;
    logic [COORD_W-1:0]    view_y;
    logic [ANGLE_W-1:0]    view_angle;
    logic [COLUMN_W-1:0]   screen_column;
    logic                  done;
    logic                  hit;
    logic [COORD_W-1:0]    hit_x;
    logic [COORD_W-1:0]    hit_y;
    logic [ANGLE_W-1:0]    ray_angle;
    logic                  vertical_face;

    ray_result_t hit_queue [$];
    bit          wall_map [0:MAP_DEPTH-1];
    int          quarter_wave [0:QSINE_LAST];
    int unsigned fov_setting;
    int unsigned cols_setting;
    int          errors;
    int          writes_sent;
    int          casts_sent;
    int          hits_seen;
    int          burst_left;
    int          run_cycles;
    bit          gaps_on;

    stim_row_t directed_rows [0:20] = '{
        {ACT_CAST,  6'd0,  6'd0,  1'b0, 20'd0,      20'd0,      12'd341,  10'd0,
            1'b1, 1'b0, 20'd0,      20'd0,      12'd0,    1'b0},
        {ACT_CAST,  6'd0,  6'd0,  1'b0, 20'd0,      20'd0,      12'd2389, 10'd0,
            1'b1, 1'b1, 20'd0,      20'd0,      12'd2048, 1'b0},
        {ACT_CAST,  6'd0,  6'd0,  1'b0, 20'd2560,   20'd0,      12'd3413, 10'd0,
            1'b1, 1'b1, 20'd2560,   20'd0,      12'd3072, 1'b1},
        {ACT_CAST,  6'd0,  6'd0,  1'b0, 20'hFFFFF,  20'hFFFFF,  12'd341,  10'd0,
            1'b1, 1'b1, 20'hFFFFF,  20'hFFFFF,  12'd0,    1'b0},
        {ACT_WRITE, 6'd1,  6'd0,  1'b1, 20'd0,      20'd0,      12'd0,    10'd0,
            1'b0, NO_RESULT},
        {ACT_CAST,  6'd0,  6'd0,  1'b0, 20'd0,      20'd0,      12'd341,  10'd0,
            1'b1, 1'b1, 20'd16384,  20'd0,      12'd0,    1'b0},
        {ACT_WRITE, 6'd1,  6'd0,  1'b0, 20'd0,      20'd0,      12'd0,    10'd0,
            1'b0, NO_RESULT},
        {ACT_WRITE, 6'd0,  6'd0,  1'b1, 20'd0,      20'd0,      12'd0,    10'd0,
            1'b0, NO_RESULT},
        {ACT_CAST,  6'd0,  6'd0,  1'b0, 20'd0,      20'd0,      12'd341,  10'd0,
            1'b1, 1'b1, 20'd0,      20'd0,      12'd0,    1'b0},
        {ACT_WRITE, 6'd0,  6'd0,  1'b0, 20'd0,      20'd0,      12'd0,    10'd0,
            1'b0, NO_RESULT},
        {ACT_WRITE, 6'd5,  6'd5,  1'b1, 20'd0,      20'd0,      12'd0,    10'd0,
            1'b0, NO_RESULT},
        {ACT_CAST,  6'd0,  6'd0,  1'b0, 20'd84480,  20'd84480,  12'd2389, 10'd0,
            1'b0, NO_RESULT},
        {ACT_CAST,  6'd0,  6'd0,  1'b0, 20'd84480,  20'd84480,  12'd341,  10'd0,
            1'b0, NO_RESULT},
        {ACT_WRITE, 6'd63, 6'd63, 1'b1, 20'd0,      20'd0,      12'd0,    10'd0,
            1'b0, NO_RESULT},
        {ACT_CAST,  6'd0,  6'd0,  1'b0, 20'd1024000, 20'd1024000, 12'd853, 10'd0,
            1'b0, NO_RESULT},
        {ACT_CAST,  6'd0,  6'd0,  1'b0, 20'd524288, 20'd524288, 12'd1365, 10'd0,
            1'b0, NO_RESULT},
        {ACT_CAST,  6'd0,  6'd0,  1'b0, 20'd524288, 20'd524288, 12'd3413, 10'd0,
            1'b0, NO_RESULT},
        {ACT_CAST,  6'd0,  6'd0,  1'b0, 20'h80000,  20'h7FFFF,  12'hFFF,  10'h3FF,
            1'b0, NO_RESULT},
        {ACT_CAST,  6'd0,  6'd0,  1'b0, 20'hFFFFF,  20'd0,      12'd0,    10'd0,
            1'b0, NO_RESULT},
        {ACT_WRITE, 6'd63, 6'd63, 1'b0, 20'd0,      20'd0,      12'd0,    10'd0,
            1'b0, NO_RESULT},
        {ACT_WRITE, 6'd5,  6'd5,  1'b0, 20'd0,      20'd0,      12'd0,    10'd0,
            1'b0, NO_RESULT}
    };

    tile_map_ray_marcher DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .tile_col      (tile_col),
        .tile_row      (tile_row),
        .tile_solid    (tile_solid),
        .view_x        (view_x),
        .view_y        (view_y),
        .view_angle    (view_angle),
        .screen_column (screen_column),
        .done          (done),
        .hit           (hit),
        .hit_x         (hit_x),
        .hit_y         (hit_y),
        .ray_angle     (ray_angle),
        .vertical_face (vertical_face)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint sine_q14(input logic [ANGLE_W-1:0] a);
        longint v;
        v = a[10] ? quarter_wave[1024 - int'(a[9:0])] : quarter_wave[int'(a[9:0])];
        return a[11] ? -v : v;
    endfunction

    function automatic logic face_off(input longint p);
        longint f;
        if (p >= 0)
            f = p >>> FRAC;
        else
            f = -(((-p) + (longint'(1) << FRAC) - 1) >>> FRAC);
        return (f % TILE_PIXELS) != 0;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_pixel(input longint p);
        longint q;
        if (p < 0)
            return '0;
        q = p >>> 6;
        return (q > longint'(HIT_LIM)) ? COORD_W'(HIT_LIM) : COORD_W'(q);
    endfunction

    function automatic ray_result_t march_ray(input word_t w);
        int unsigned        cols;
        int unsigned        spread;
        int                 ang_sum;
        logic [ANGLE_W-1:0] ang;
        longint             cs;
        longint             sn;
        longint             px;
        longint             py;
        logic               face;
        ray_result_t        r;
        cols    = (cols_setting == 0) ? 1 : cols_setting;
        spread  = (fov_setting * w.screen_column) / cols;
        ang_sum = int'(w.view_angle) + 4096 - int'(fov_setting >> 1) + int'(spread);
        ang     = ang_sum[ANGLE_W-1:0];
        cs      = sine_q14(ang + ANG_QUARTER);
        sn      = sine_q14(ang);
        r       = '0;
        r.ray_angle = ang;
        for (int i = 0; i < MAX_STEPS; i++) begin
            px = (longint'(w.view_x) << 6) + cs * i;
            py = (longint'(w.view_y) << 6) + sn * i;
            if (px < 0 || py < 0 || px / TILE_SPAN >= MAP_SIDE || py / TILE_SPAN >= MAP_SIDE
                || wall_map[(py / TILE_SPAN) * MAP_SIDE + px / TILE_SPAN]) begin
                face = face_off(px);
                if (face && ang > ANG_QUARTER && ang < ANG_THREE_Q) begin
                    px   = px + (longint'(1) << FRAC);
                    face = face_off(px);
                end
                r.hit           = 1'b1;
                r.hit_x         = clamp_pixel(px);
                r.hit_y         = clamp_pixel(py);
                r.vertical_face = face;
                return r;
            end
        end
        return r;
    endfunction

    task automatic send_word(input word_t w, input logic typed, input ray_result_t want);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        start         <= 1'b1;
        action        <= w.action;
        tile_col      <= w.tile_col;
        tile_row      <= w.tile_row;
        tile_solid    <= w.tile_solid;
        view_x        <= w.view_x;
        view_y        <= w.view_y;
        view_angle    <= w.view_angle;
        screen_column <= w.screen_column;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (w.action == ACT_WRITE) begin
            wall_map[{w.tile_row, w.tile_col}] = w.tile_solid;
            writes_sent++;
        end
        else begin
            hit_queue.insert(hit_queue.size(), typed ? want : march_ray(w));
            casts_sent++;
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (hit_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_FIELD_OF_VIEW)
            fov_setting = value;
        else
            cols_setting = value[COLS_W-1:0];
        @(posedge clk);
    endtask

    task automatic check_field(input string label, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin : check_results
        ray_result_t want;
        if (rst_n && done) begin
            if (hit_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, got hit %0b x %0h y %0h angle %0d",
                         $time, hit, hit_x, hit_y, ray_angle);
                errors++;
            end
            else begin
                want = hit_queue.pop_front();
                check_field("hit", want.hit, hit);
                check_field("hit_x", want.hit_x, hit_x);
                check_field("hit_y", want.hit_y, hit_y);
                check_field("ray_angle", want.ray_angle, ray_angle);
                check_field("vertical_face", want.vertical_face, vertical_face);
                if (hit === 1'b1)
                    hits_seen++;
            end
        end
    end

    always @(posedge clk) begin
        run_cycles <= run_cycles + 1;
        if (run_cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, hit_queue.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        longint unsigned     x;
        longint unsigned     x2;
        longint unsigned     term;
        longint              acc;
        word_t               w;
        logic [95:0]         noise;
        logic [COORD_W-1:0]  vx;
        logic [COORD_W-1:0]  vy;
        int                  tx;
        int                  ty;
        int                  c;
        int                  rw;
        int                  sent;
        int                  col_top;
        for (int k = 0; k <= QSINE_LAST; k++) begin
            x    = k;
            x    = (x * 843314857) / 2048;
            x2   = (x * x) >> 28;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 28) / ((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            acc = (acc + 8192) >>> 14;
            quarter_wave[k] = (acc > 16384) ? 16384 : int'(acc);
        end
        errors        = 0;
        writes_sent   = 0;
        casts_sent    = 0;
        hits_seen     = 0;
        burst_left    = 0;
        gaps_on       = 1'b1;
        fov_setting   = FOV_RESET;
        cols_setting  = COLS_RESET;
        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= REG_FIELD_OF_VIEW;
        cfg_data      <= '0;
        start         <= 1'b0;
        action        <= ACT_WRITE;
        tile_col      <= '0;
        tile_row      <= '0;
        tile_solid    <= 1'b0;
        view_x        <= '0;
        view_y        <= '0;
        view_angle    <= '0;
        screen_column <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    write_reg(REG_FIELD_OF_VIEW, 12'd0);
                    write_reg(REG_COLUMN_COUNT, 12'd1);
                end
                1: begin
                    write_reg(REG_FIELD_OF_VIEW, 12'd4095);
                    write_reg(REG_COLUMN_COUNT, 12'd1024);
                end
                2: begin
                    write_reg(REG_COLUMN_COUNT, 12'd0);
                end
                3: begin
                    write_reg(REG_FIELD_OF_VIEW, 12'd1);
                    write_reg(REG_COLUMN_COUNT, 12'hFFF);
                end
                4: begin
                    write_reg(REG_FIELD_OF_VIEW, CFG_W'($urandom_range(0, 4095)));
                    write_reg(REG_COLUMN_COUNT, CFG_W'($urandom_range(1, 1024)));
                end
                default: begin
                    write_reg(REG_FIELD_OF_VIEW, CFG_W'(FOV_RESET));
                    write_reg(REG_COLUMN_COUNT, CFG_W'(COLS_RESET));
                end
            endcase
            gaps_on    = (ph != 1);
            burst_left = 0;
            col_top    = (cols_setting == 0) ? 0 :
                         ((cols_setting > 1024) ? 1023 : int'(cols_setting) - 1);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 7) begin
                    tx = $urandom_range(0, MAP_SIDE - 1);
                    ty = $urandom_range(0, MAP_SIDE - 1);
                    vx = COORD_W'(tx * TILE_PIXELS * 256 + $urandom_range(0, TILE_PIXELS * 256 - 1));
                    vy = COORD_W'(ty * TILE_PIXELS * 256 + $urandom_range(0, TILE_PIXELS * 256 - 1));
                    repeat ($urandom_range(1, 4)) begin
                        c  = tx + $urandom_range(0, 6) - 3;
                        rw = ty + $urandom_range(0, 6) - 3;
                        c  = (c < 0) ? 0 : ((c >= MAP_SIDE) ? MAP_SIDE - 1 : c);
                        rw = (rw < 0) ? 0 : ((rw >= MAP_SIDE) ? MAP_SIDE - 1 : rw);
                        w            = '0;
                        w.action     = ACT_WRITE;
                        w.tile_col   = c[TILE_W-1:0];
                        w.tile_row   = rw[TILE_W-1:0];
                        w.tile_solid = ($urandom_range(0, 9) < 7);
                        send_word(w, 1'b0, NO_RESULT);
                        sent++;
                    end
                    repeat ($urandom_range(1, 3)) begin
                        w            = '0;
                        w.action     = ACT_CAST;
                        w.view_x     = vx;
                        w.view_y     = vy;
                        w.view_angle = ANGLE_W'($urandom);
                        w.screen_column = ($urandom_range(0, 3) == 0) ? COLUMN_W'($urandom) :
                                          COLUMN_W'($urandom_range(0, col_top));
                        send_word(w, 1'b0, NO_RESULT);
                        sent++;
                    end
                end
                else begin
                    noise = {$urandom, $urandom, $urandom};
                    w     = noise[$bits(word_t)-1:0];
                    send_word(w, 1'b0, NO_RESULT);
                    sent++;
                end
            end
        end

        wait_drained();
        $display("covered %0d tile writes and %0d casts, %0d of them meeting a wall,",
                 writes_sent, casts_sent, hits_seen);
        $display("across seven field of view and column count settings");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
